// ----- hw/rtl/euler_xyz_line_rotation_assert.svh -----
// assertion macros shared by the sincos and axis rotation rtl files
`ifndef EULER_XYZ_LINE_ROTATION_ASSERT_SVH
`define EULER_XYZ_LINE_ROTATION_ASSERT_SVH

// same-cycle implication
`define EXYZ_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication
`define EXYZ_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/exyz_pkg.sv -----
package exyz_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int ANGLE_WIDTH_DEF = 16;

  localparam int NUM_POINTS  = 2;
  localparam int NUM_AXES    = 3;
  localparam int CFG_INDEX_W = 2;

  // cordic: 32 bits per turn for angles, 30 fractional bits for x and y
  localparam int TURN_W       = 32;
  localparam int CORDIC_W     = 34;
  localparam int CORDIC_FRAC  = 30;
  localparam int CORDIC_STEPS = 28;
  localparam int STEP_W       = 5;
  localparam int CORDIC_GAIN  = 652032874;

  localparam logic [TURN_W-1:0] ATAN_TURN32 [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5
  };

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_X_ANGLE = 2'd0,
    REG_Y_ANGLE = 2'd1,
    REG_Z_ANGLE = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_LOAD,
    SC_ITER,
    SC_DONE
  } sc_state_e;

endpackage

// ----- hw/rtl/exyz_sincos.sv -----
`include "euler_xyz_line_rotation_assert.svh"

module exyz_sincos #(
  parameter int FRAC_BITS   = exyz_pkg::FRAC_BITS_DEF,
  parameter int ANGLE_WIDTH = exyz_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          cfg_valid_i,
  input  logic [exyz_pkg::CFG_INDEX_W-1:0]              cfg_index_i,
  input  logic [ANGLE_WIDTH-1:0]                        cfg_data_i,
  output logic                                          busy_o,
  output logic [exyz_pkg::NUM_AXES-1:0][FRAC_BITS+1:0]  cos_o,
  output logic [exyz_pkg::NUM_AXES-1:0][FRAC_BITS+1:0]  sin_o
);
  import exyz_pkg::*;

  localparam int TRIG_W = FRAC_BITS + 2;
  localparam int SH     = CORDIC_FRAC - FRAC_BITS;
  localparam int PAD_W  = TURN_W - ANGLE_WIDTH;
  localparam logic signed [CORDIC_W-1:0] HALF = CORDIC_W'(1) <<< (SH - 1);
  localparam logic signed [CORDIC_W-1:0] ONE  = CORDIC_W'(1) <<< FRAC_BITS;

  sc_state_e state_q, state_d;
  logic [CFG_INDEX_W-1:0] sel_q, sel_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic signed [CORDIC_W-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic flip_q, flip_d;
  logic [NUM_AXES-1:0][ANGLE_WIDTH-1:0] ang_q, ang_d;
  logic [NUM_AXES-1:0][TRIG_W-1:0] cos_q, cos_d, sin_q, sin_d;

  logic [TURN_W-1:0] z32, zf;
  logic fold;
  logic signed [CORDIC_W-1:0] dx, dy, atan_s, xf, yf, xr, yr, xc, yc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_LOAD;
      sel_q   <= REG_X_ANGLE;
      ang_q   <= '0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      ang_q   <= ang_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    flip_q <= flip_d;
    cos_q  <= cos_d;
    sin_q  <= sin_d;
  end

  always_comb begin
    // fold angle into a quarter turn either side of zero
    z32  = {ang_q[sel_q], {PAD_W{1'b0}}};
    fold = (!z32[TURN_W-1] && z32[TURN_W-2] && (|z32[TURN_W-3:0])) ||
           (z32[TURN_W-1] && !z32[TURN_W-2]);
    zf   = fold ? {~z32[TURN_W-1], z32[TURN_W-2:0]} : z32;

    dx     = y_q >>> step_q;
    dy     = x_q >>> step_q;
    atan_s = CORDIC_W'(ATAN_TURN32[step_q]);

    xf = flip_q ? -x_q : x_q;
    yf = flip_q ? -y_q : y_q;
    xr = (xf + HALF) >>> SH;
    yr = (yf + HALF) >>> SH;
    xc = (xr > ONE) ? ONE : ((xr < -ONE) ? -ONE : xr);
    yc = (yr > ONE) ? ONE : ((yr < -ONE) ? -ONE : yr);

    state_d = state_q;
    sel_d   = sel_q;
    step_d  = step_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    flip_d  = flip_q;
    ang_d   = ang_q;
    cos_d   = cos_q;
    sin_d   = sin_q;

    case (state_q)
      SC_IDLE: begin
      end
      SC_LOAD: begin
        x_d     = CORDIC_W'(CORDIC_GAIN);
        y_d     = '0;
        z_d     = CORDIC_W'($signed(zf));
        flip_d  = fold;
        step_d  = '0;
        state_d = SC_ITER;
      end
      SC_ITER: begin
        if (!z_q[CORDIC_W-1]) begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - atan_s;
        end else begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + atan_s;
        end
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
          state_d = SC_DONE;
        end
      end
      SC_DONE: begin
        cos_d[sel_q] = xc[TRIG_W-1:0];
        sin_d[sel_q] = yc[TRIG_W-1:0];
        if (sel_q == REG_Z_ANGLE) begin
          state_d = SC_IDLE;
        end else begin
          sel_d   = sel_q + CFG_INDEX_W'(1);
          state_d = SC_LOAD;
        end
      end
      default: begin
        state_d = SC_IDLE;
      end
    endcase

    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_X_ANGLE: ang_d[REG_X_ANGLE] = cfg_data_i;
        REG_Y_ANGLE: ang_d[REG_Y_ANGLE] = cfg_data_i;
        REG_Z_ANGLE: ang_d[REG_Z_ANGLE] = cfg_data_i;
        default: begin
        end
      endcase
      state_d = SC_LOAD;
      sel_d   = REG_X_ANGLE;
    end
  end

  assign busy_o = (state_q != SC_IDLE);
  assign cos_o  = cos_q;
  assign sin_o  = sin_q;

  `EXYZ_ASSERT_NEXT(a_cfg_restarts, cfg_valid_i, busy_o)
  `EXYZ_ASSERT_NEXT(a_trig_hold, !busy_o && !cfg_valid_i, $stable(cos_q) && $stable(sin_q))
  `EXYZ_ASSERT_NEXT(a_done_next, state_q == SC_DONE, state_q == SC_IDLE || state_q == SC_LOAD)

endmodule

// ----- hw/rtl/exyz_axis_rot.sv -----
`include "euler_xyz_line_rotation_assert.svh"

module exyz_axis_rot #(
  parameter int COORD_WIDTH = exyz_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = exyz_pkg::FRAC_BITS_DEF,
  parameter int AXIS        = 0
) (
  input  logic                                                          clk_i,
  input  logic                                                          rst_ni,
  input  logic                                                          in_valid_i,
  output logic                                                          in_ready_o,
  input  logic [exyz_pkg::NUM_POINTS-1:0][exyz_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] in_pts_i,
  input  logic signed [FRAC_BITS+1:0]                                   cos_i,
  input  logic signed [FRAC_BITS+1:0]                                   sin_i,
  output logic                                                          out_valid_o,
  input  logic                                                          out_ready_i,
  output logic [exyz_pkg::NUM_POINTS-1:0][exyz_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0] out_pts_o
);
  import exyz_pkg::*;

  localparam int TRIG_W = FRAC_BITS + 2;
  localparam int PW     = COORD_WIDTH + TRIG_W;
  localparam int SW     = PW + 2;
  localparam int P      = (AXIS + 1) % NUM_AXES;
  localparam int Q      = (AXIS + 2) % NUM_AXES;
  localparam logic signed [SW-1:0] HALF =
    {{(SW - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
  localparam logic signed [SW-1:0] MAXV =
    {{(SW - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
  localparam logic signed [SW-1:0] MINV =
    {{(SW - COORD_WIDTH + 1){1'b1}}, {(COORD_WIDTH - 1){1'b0}}};

  function automatic logic [COORD_WIDTH-1:0] sat_round(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    t = (v + HALF) >>> FRAC_BITS;
    if (t > MAXV) begin
      return MAXV[COORD_WIDTH-1:0];
    end else if (t < MINV) begin
      return MINV[COORD_WIDTH-1:0];
    end
    return t[COORD_WIDTH-1:0];
  endfunction

  logic v1_q, v2_q, en1, en2;
  logic [NUM_POINTS-1:0][PW-1:0] pc_q, qs_q, ps_q, qc_q;
  logic [NUM_POINTS-1:0][COORD_WIDTH-1:0] r1_q, np, nq;
  logic [NUM_POINTS-1:0][NUM_AXES-1:0][COORD_WIDTH-1:0] pts2_q;

  assign en2        = !v2_q || out_ready_i;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
    end
  end

  // products
  always_ff @(posedge clk_i) begin
    if (en1) begin
      for (int k = 0; k < NUM_POINTS; k++) begin
        pc_q[k] <= PW'($signed(in_pts_i[k][P])) * PW'(cos_i);
        qs_q[k] <= PW'($signed(in_pts_i[k][Q])) * PW'(sin_i);
        ps_q[k] <= PW'($signed(in_pts_i[k][P])) * PW'(sin_i);
        qc_q[k] <= PW'($signed(in_pts_i[k][Q])) * PW'(cos_i);
        r1_q[k] <= in_pts_i[k][AXIS];
      end
    end
  end

  // sums, rounding and saturation
  always_comb begin
    for (int k = 0; k < NUM_POINTS; k++) begin
      np[k] = sat_round(SW'($signed(pc_q[k])) - SW'($signed(qs_q[k])));
      nq[k] = sat_round(SW'($signed(ps_q[k])) + SW'($signed(qc_q[k])));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      for (int k = 0; k < NUM_POINTS; k++) begin
        pts2_q[k][P]    <= np[k];
        pts2_q[k][Q]    <= nq[k];
        pts2_q[k][AXIS] <= r1_q[k];
      end
    end
  end

  assign out_valid_o = v2_q;
  assign out_pts_o   = pts2_q;

  `EXYZ_ASSERT_NEXT(a_enter_stage1, in_valid_i && in_ready_o, v1_q)
  `EXYZ_ASSERT_NEXT(a_move_stage2, v1_q && en2, v2_q)
  `EXYZ_ASSERT_NEXT(a_stage1_hold, v1_q && !en2, v1_q && $stable(pc_q) && $stable(qs_q))

endmodule

// ----- hw/rtl/euler_xyz_line_rotation.sv -----
// an accepted input request reaches its output request through
//   two register stages (multiply, then sum/round/saturate) for each of x, y and z
// throughput: one segment per cycle while the cordic is idle; a stalled output holds stage by stage
// reset: clears valid bits and angles; then one shared cordic forms sine and cosine
//   of all three angles in turn, with s_axis_tready low
// every configuration write restarts that pass
module euler_xyz_line_rotation #(
  parameter int COORD_WIDTH = exyz_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = exyz_pkg::FRAC_BITS_DEF,
  parameter int ANGLE_WIDTH = exyz_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z
  input  logic [((exyz_pkg::NUM_POINTS * exyz_pkg::NUM_AXES * COORD_WIDTH + 7) / 8) * 8 - 1:0]
                                                 s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // rot_start_x, rot_start_y, rot_start_z, rot_end_x, rot_end_y, rot_end_z
  output logic [((exyz_pkg::NUM_POINTS * exyz_pkg::NUM_AXES * COORD_WIDTH + 7) / 8) * 8 - 1:0]
                                                 m_axis_tdata,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [exyz_pkg::CFG_INDEX_W-1:0]       cfg_index_i,
  input  logic [ANGLE_WIDTH-1:0]                 cfg_data_i
);
  import exyz_pkg::*;

  localparam int PTS_W  = NUM_POINTS * NUM_AXES * COORD_WIDTH;
  localparam int DATA_W = ((PTS_W + 7) / 8) * 8;
  localparam int TRIG_W = FRAC_BITS + 2;

  logic busy;
  logic [NUM_AXES-1:0][TRIG_W-1:0] cos_w, sin_w;
  logic [NUM_AXES:0] valid_w, ready_w;
  logic [NUM_AXES:0][NUM_POINTS-1:0][NUM_AXES-1:0][COORD_WIDTH-1:0] pts_w;

  assign cfg_ready_o = 1'b1;

  exyz_sincos #(
    .FRAC_BITS  (FRAC_BITS),
    .ANGLE_WIDTH(ANGLE_WIDTH)
  ) u_sincos (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .busy_o     (busy),
    .cos_o      (cos_w),
    .sin_o      (sin_w)
  );

  assign valid_w[0]    = s_axis_tvalid && !busy;
  assign s_axis_tready = ready_w[0] && !busy;
  assign pts_w[0]      = s_axis_tdata[PTS_W-1:0];

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    exyz_axis_rot #(
      .COORD_WIDTH(COORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS),
      .AXIS       (a)
    ) u_rot (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (valid_w[a]),
      .in_ready_o (ready_w[a]),
      .in_pts_i   (pts_w[a]),
      .cos_i      (cos_w[a]),
      .sin_i      (sin_w[a]),
      .out_valid_o(valid_w[a+1]),
      .out_ready_i(ready_w[a+1]),
      .out_pts_o  (pts_w[a+1])
    );
  end

  assign ready_w[NUM_AXES] = m_axis_tready;
  assign m_axis_tvalid     = valid_w[NUM_AXES];
  assign m_axis_tdata      = DATA_W'(pts_w[NUM_AXES]);

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  typedef logic [5:0][31:0] seg_t;
  typedef logic [2:0][15:0] angles_t;

  typedef struct {
    angles_t ang;
    seg_t    seg;
    bit      typed;
    seg_t    want;
  } dir_row_t;

  localparam logic [31:0] C_MAX = 32'h7fff_ffff;
  localparam logic [31:0] C_MIN = 32'h8000_0000;
  localparam logic [31:0] C_ONE = 32'h0001_0000;

  localparam logic [1:0] REG_NONE = 2'd3;

  localparam longint TURN_QTR  = 64'sd1073741824;
  localparam longint TURN_HALF = 64'sd2147483648;
  localparam longint TURN_FULL = 64'sd4294967296;
  localparam longint UNIT      = 64'sd65536;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  seg_t s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  seg_t m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  seg_t rotated_seg_q [$];
  dir_row_t dir_tab [$];
  angles_t angle_copy = '0;
  longint cos_of [3] = '{UNIT, UNIT, UNIT};
  longint sin_of [3] = '{0, 0, 0};
  int mismatch_cnt = 0;
  bit idle_on = 1'b0;
  int stall_cnt = 0;
  seg_t oldest_seg;
  string field_names [6] = '{"rot_start_x", "rot_start_y", "rot_start_z",
                             "rot_end_x", "rot_end_y", "rot_end_z"};

  euler_xyz_line_rotation u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic longint clip_unit(input longint v);
    if (v > UNIT) return UNIT;
    if (v < -UNIT) return -UNIT;
    return v;
  endfunction

  function automatic longint clip_coord(input longint v);
    longint r;
    r = (v + 64'sd32768) >>> 16;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  // cordic sine and cosine, one turn is 2^16 angle units
  function automatic void axis_sin_cos(input logic [15:0] ang, output longint c,
                                       output longint s);
    longint x, y, z, dx, dy;
    bit flip;
    x = longint'(exyz_pkg::CORDIC_GAIN);
    y = 0;
    flip = 1'b0;
    z = longint'({ang, 16'h0000});
    if (z >= TURN_HALF) z -= TURN_FULL;
    if (z > TURN_QTR) begin
      z -= TURN_HALF;
      flip = 1'b1;
    end else if (z < -TURN_QTR) begin
      z += TURN_HALF;
      flip = 1'b1;
    end
    for (int i = 0; i < exyz_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(exyz_pkg::ATAN_TURN32[i]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(exyz_pkg::ATAN_TURN32[i]);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clip_unit((x + 64'sd8192) >>> 14);
    s = clip_unit((y + 64'sd8192) >>> 14);
  endfunction

  // x then y then z rotation of both endpoints, saturating after each stage
  function automatic seg_t rotate_segment(input seg_t seg);
    longint pt [6];
    longint np, nq;
    int pa, qa;
    seg_t res;
    for (int k = 0; k < 6; k++) pt[k] = longint'($signed(seg[k]));
    for (int b = 0; b < 6; b += 3) begin
      for (int a = 0; a < 3; a++) begin
        pa = b + (a + 1) % 3;
        qa = b + (a + 2) % 3;
        np = clip_coord(pt[pa] * cos_of[a] - pt[qa] * sin_of[a]);
        nq = clip_coord(pt[pa] * sin_of[a] + pt[qa] * cos_of[a]);
        pt[pa] = np;
        pt[qa] = nq;
      end
    end
    for (int k = 0; k < 6; k++) res[k] = pt[k][31:0];
    return res;
  endfunction

  function automatic seg_t mk_seg(input logic [31:0] sx, sy, sz, ex, ey, ez);
    return {ez, ey, ex, sz, sy, sx};
  endfunction

  function automatic angles_t mk_angles(input logic [15:0] ax, ay, az);
    return {az, ay, ax};
  endfunction

  function automatic void add_dir_row(input angles_t ang, input seg_t seg, input bit typed,
                                      input seg_t want);
    dir_row_t row;
    row.ang = ang;
    row.seg = seg;
    row.typed = typed;
    row.want = want;
    dir_tab.push_back(row);
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0, 1: return $urandom;
      2: return 32'($urandom_range(0, 2097152)) - 32'd1048576;
      3: return 32'($urandom_range(0, 33554432)) - 32'd16777216;
      4: begin
        case ($urandom_range(0, 4))
          0: return C_MAX;
          1: return C_MIN;
          2: return 32'd0;
          3: return 32'hffff_ffff;
          default: return C_ONE;
        endcase
      end
      default: return 32'($urandom_range(0, 8388608)) - 32'd4194304;
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'h4000;
      3: return 16'h8000;
      4: return 16'hc000;
      5: return 16'h2000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic write_angle_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    if (idx <= exyz_pkg::REG_Z_ANGLE) begin
      angle_copy[idx] = val;
      axis_sin_cos(val, cos_of[idx], sin_of[idx]);
    end
  endtask

  task automatic push_segment(input seg_t seg, input bit typed, input seg_t want);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= seg;
    do @(posedge clk_i); while (!s_axis_tready);
    if (typed) rotated_seg_q.push_back(want);
    else rotated_seg_q.push_back(rotate_segment(seg));
  endtask

  task automatic drain_segments();
    s_axis_tvalid <= 1'b0;
    while (rotated_seg_q.size() != 0) @(posedge clk_i);
  endtask

  // output side back-pressure
  always @(posedge clk_i) begin
    if (stall_cnt != 0) begin
      stall_cnt <= stall_cnt - 1;
      m_axis_tready <= (stall_cnt == 1);
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_cnt <= $urandom_range(1, 4);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (rotated_seg_q.size() == 0) begin
        $error("output request with no segment pending");
        mismatch_cnt++;
      end else begin
        oldest_seg = rotated_seg_q.pop_front();
        for (int k = 0; k < 6; k++) begin
          if (m_axis_tdata[k] !== oldest_seg[k]) begin
            $error("%s expected %0d got %0d", field_names[k], $signed(oldest_seg[k]),
                   $signed(m_axis_tdata[k]));
            mismatch_cnt++;
          end
        end
      end
    end
  end

  initial begin
    angles_t a_zero, a_half_x, a_eighth, a_top;
    a_zero   = mk_angles(16'd0, 16'd0, 16'd0);
    a_half_x = mk_angles(16'h8000, 16'd0, 16'd0);
    a_eighth = mk_angles(16'h2000, 16'h2000, 16'h2000);
    a_top    = mk_angles(16'hffff, 16'hffff, 16'hffff);

    // zero angles leave the segment untouched
    add_dir_row(a_zero, '0, 1'b1, '0);
    add_dir_row(a_zero, {6{C_MAX}}, 1'b1, {6{C_MAX}});
    add_dir_row(a_zero, {6{C_MIN}}, 1'b1, {6{C_MIN}});
    add_dir_row(a_zero, {3{C_MIN, C_MAX}}, 1'b1, {3{C_MIN, C_MAX}});
    add_dir_row(a_zero, mk_seg(-1, 1, C_ONE, -C_ONE, 32'h5555_5555, 32'haaaa_aaaa), 1'b1,
                mk_seg(-1, 1, C_ONE, -C_ONE, 32'h5555_5555, 32'haaaa_aaaa));
    // half turn about x negates y and z, saturating
    add_dir_row(a_half_x, mk_seg(C_ONE, 2 * C_ONE, 3 * C_ONE, C_MIN, C_MIN, C_MAX), 1'b1,
                mk_seg(C_ONE, -2 * C_ONE, -3 * C_ONE, C_MIN, C_MAX, 32'h8000_0001));
    add_dir_row(a_half_x, mk_seg(32'h1234_5678, -32'h0abc_def0, 7, C_MAX, 0, C_MIN), 1'b0, '0);
    add_dir_row(a_eighth, {6{C_MAX}}, 1'b0, '0);
    add_dir_row(a_eighth, {6{C_MIN}}, 1'b0, '0);
    add_dir_row(a_eighth, {3{C_MAX, C_MIN}}, 1'b0, '0);
    add_dir_row(a_eighth, mk_seg(C_ONE, C_ONE, C_ONE, -C_ONE, 0, 1), 1'b0, '0);
    add_dir_row(a_top, {3{C_MIN, C_MAX}}, 1'b0, '0);
    add_dir_row(a_top, mk_seg(C_ONE, -C_ONE, 32'h0000_8000, 5, -5, 32'h0100_0000), 1'b0, '0);
    add_dir_row(mk_angles(16'd0, 16'h4000, 16'd0),
                mk_seg(C_ONE, 2 * C_ONE, 3 * C_ONE, C_MAX, C_MIN, C_MAX), 1'b0, '0);
    add_dir_row(mk_angles(16'd0, 16'd0, 16'hc000),
                mk_seg(C_ONE, 2 * C_ONE, 3 * C_ONE, C_MIN, C_MAX, 0), 1'b0, '0);
    add_dir_row(mk_angles(16'h4000, 16'h4000, 16'h4000),
                mk_seg(C_ONE, 2 * C_ONE, 3 * C_ONE, -1, C_MAX, C_MIN), 1'b0, '0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    idle_on <= 1'b1;

    foreach (dir_tab[r]) begin
      if (dir_tab[r].ang != angle_copy) begin
        drain_segments();
        for (int a = 0; a < 3; a++) begin
          if (dir_tab[r].ang[a] != angle_copy[a]) write_angle_reg(2'(a), dir_tab[r].ang[a]);
        end
      end
      push_segment(dir_tab[r].seg, dir_tab[r].typed, dir_tab[r].want);
    end

    for (int ph = 0; ph < 12; ph++) begin
      drain_segments();
      idle_on <= (ph != 11) && ($urandom_range(0, 3) != 0);
      if (ph == 0) begin
        write_angle_reg(exyz_pkg::REG_X_ANGLE, 16'hffff);
        write_angle_reg(exyz_pkg::REG_Y_ANGLE, 16'hffff);
        write_angle_reg(exyz_pkg::REG_Z_ANGLE, 16'hffff);
      end else if (ph == 1) begin
        write_angle_reg(exyz_pkg::REG_Z_ANGLE, 16'd0);
        write_angle_reg(exyz_pkg::REG_X_ANGLE, 16'd0);
        write_angle_reg(exyz_pkg::REG_Y_ANGLE, 16'd0);
      end else begin
        write_angle_reg(exyz_pkg::REG_X_ANGLE, pick_angle());
        write_angle_reg(exyz_pkg::REG_Y_ANGLE, pick_angle());
        write_angle_reg(exyz_pkg::REG_Z_ANGLE, pick_angle());
      end
      // unmapped index must be ignored
      if (ph % 3 == 0) write_angle_reg(REG_NONE, 16'($urandom));
      repeat (170) begin
        push_segment(mk_seg(rand_coord(), rand_coord(), rand_coord(),
                            rand_coord(), rand_coord(), rand_coord()), 1'b0, '0);
      end
    end

    drain_segments();
    repeat (16) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
